@@ sv/cisw_pkg.sv @@
`default_nettype none

package cisw_pkg;

  localparam int NEST_DEPTH_DEF = 8;
  localparam int COUNT_BITS_DEF = 32;

  // Additional-info boundaries of a header byte.
  localparam logic [4:0] INFO_DIRECT_MAX = 5'd23;
  localparam logic [4:0] INFO_ARG8       = 5'd27;

  // Major types that the walker treats specially.
  localparam logic [2:0] MT_BSTR  = 3'd2;
  localparam logic [2:0] MT_TSTR  = 3'd3;
  localparam logic [2:0] MT_ARRAY = 3'd4;
  localparam logic [2:0] MT_MAP   = 3'd5;
  localparam logic [2:0] MT_TAG   = 3'd6;

  typedef enum logic [1:0] {
    EV_PENDING = 2'd0,
    EV_HEADER  = 2'd1,
    EV_PAYLOAD = 2'd2,
    EV_ERROR   = 2'd3
  } event_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_RESERVED = 3'd1,
    ERR_TRUNC    = 3'd2,
    ERR_DEEP     = 3'd3,
    ERR_WIDE     = 3'd4
  } err_t;

  typedef struct packed {
    logic capture;
    logic step;
    logic fin_read;
    logic fin_check;
    logic finalize;
  } cisw_cmd_t;

  typedef struct packed {
    logic finish;
    logic sp_zero;
    logic pop;
    logic out_free;
  } cisw_stat_t;

endpackage

`default_nettype wire

@@ sv/cisw_ctrl.sv @@
`default_nettype none

module cisw_ctrl
  import cisw_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire cisw_stat_t stat,
  output cisw_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP,
    S_FIN,
    S_FIN_CHK,
    S_FINAL
  } state_t;

  state_t state, state_next;
  logic   ready, ready_next;

  assign s_tready = ready;

  always_comb begin
    state_next = state;
    ready_next = ready;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        ready_next = 1'b1;
        if (ready && s_tvalid) begin
          cmd.capture = 1'b1;
          ready_next  = 1'b0;
          state_next  = S_STEP;
        end
      end
      S_STEP: begin
        cmd.step   = 1'b1;
        state_next = stat.finish ? S_FIN : S_FINAL;
      end
      S_FIN: begin
        cmd.fin_read = 1'b1;
        state_next   = stat.sp_zero ? S_FINAL : S_FIN_CHK;
      end
      S_FIN_CHK: begin
        cmd.fin_check = 1'b1;
        state_next    = stat.pop ? S_FIN : S_FINAL;
      end
      S_FINAL: begin
        if (stat.out_free) begin
          cmd.finalize = 1'b1;
          ready_next   = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ready <= 1'b0;
    end else begin
      state <= state_next;
      ready <= ready_next;
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    ready |-> state == S_IDLE)
    else $error("ready raised outside idle");

  a_chk_follows: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN_CHK |-> $past(state) == S_FIN)
    else $error("stack check without preceding read");

endmodule

`default_nettype wire

@@ sv/cisw_dpath.sv @@
`default_nettype none

module cisw_dpath
  import cisw_pkg::*;
#(
  parameter int NEST_DEPTH = NEST_DEPTH_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [7:0] in_byte,
  input  wire logic       end_of_buffer,
  input  wire cisw_cmd_t  cmd,
  output cisw_stat_t      stat,
  input  wire logic       m_tready,
  output logic            m_tvalid,
  output logic [1:0]      event_res,
  output logic [2:0]      major_type,
  output logic [63:0]     argument,
  output logic [7:0]      data_byte,
  output logic [3:0]      nest_depth,
  output logic            item_done,
  output logic [2:0]      error_code
);

  localparam int CW   = COUNT_BITS + 1;
  localparam int SP_W = $clog2(NEST_DEPTH + 1);
  localparam int AW   = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_ARG,
    PH_PAYLOAD,
    PH_ERROR
  } phase_t;

  // captured item
  logic [7:0] in_q;
  logic       eob_q;

  // parse state
  phase_t      phase, phase_next;
  logic [3:0]  arg_left, arg_left_next;
  logic [63:0] arg_acc, arg_acc_next;
  logic [2:0]  cur_major, cur_major_next;
  logic [63:0] payload_left, payload_left_next;
  err_t        sticky, sticky_next;
  logic [SP_W-1:0] sp, sp_next;

  // per-item results
  event_t      res_event, res_event_next;
  logic [63:0] res_arg, res_arg_next;
  logic [7:0]  res_data, res_data_next;
  err_t        err_step, err_step_next;
  logic        done_flag, done_flag_next;

  // count stack
  logic [CW-1:0] count_stack [NEST_DEPTH];
  logic [CW-1:0] rd_data;
  logic          rd_en, wr_en;
  logic [AW-1:0] wr_addr, top_addr;
  logic [CW-1:0] wr_data;

  // decode helpers
  logic [4:0]    info;
  logic [2:0]    hd_major;
  logic [63:0]   hd_val;
  logic          hd_go;
  logic [63:0]   acc_new;
  logic [3:0]    left_new;
  logic [63:0]   pay_new;
  logic          fin_req;
  logic          push_req;
  logic [CW-1:0] push_val;
  logic [SP_W-1:0] sp_m1;
  logic [SP_W+3:0] sp_ext;
  err_t          fin_err;

  logic          o_valid;
  event_t        o_event;
  logic [2:0]    o_major;
  logic [63:0]   o_arg;
  logic [7:0]    o_data;
  logic [3:0]    o_depth;
  logic          o_done;
  err_t          o_err;

  assign info     = in_q[4:0];
  assign acc_new  = {arg_acc[55:0], in_q};
  assign left_new = (arg_left != 4'd0) ? arg_left - 4'd1 : arg_left;
  assign pay_new  = (payload_left != 64'd0) ? payload_left - 64'd1 : payload_left;
  assign sp_m1    = sp - SP_W'(1);
  assign top_addr = sp_m1[AW-1:0];
  assign sp_ext   = {4'b0000, sp};

  assign stat.finish   = fin_req;
  assign stat.sp_zero  = (sp == '0);
  assign stat.pop      = (rd_data <= CW'(1));
  assign stat.out_free = !o_valid || m_tready;

  always_comb begin
    phase_next        = phase;
    arg_left_next     = arg_left;
    arg_acc_next      = arg_acc;
    cur_major_next    = cur_major;
    payload_left_next = payload_left;
    sp_next           = sp;
    res_event_next    = res_event;
    res_arg_next      = res_arg;
    res_data_next     = res_data;
    err_step_next     = err_step;
    done_flag_next    = done_flag;
    fin_req           = 1'b0;
    push_req          = 1'b0;
    push_val          = '0;
    hd_go             = 1'b0;
    hd_major          = cur_major;
    hd_val            = '0;
    rd_en             = 1'b0;
    wr_en             = 1'b0;
    wr_addr           = top_addr;
    wr_data           = '0;

    if (cmd.step) begin
      res_event_next = EV_PENDING;
      res_arg_next   = '0;
      res_data_next  = '0;
      err_step_next  = ERR_NONE;
      done_flag_next = 1'b0;
      if (sticky == ERR_NONE) begin
        case (phase)
          PH_HEADER: begin
            hd_major       = in_q[7:5];
            cur_major_next = in_q[7:5];
            if (info <= INFO_DIRECT_MAX) begin
              hd_go  = 1'b1;
              hd_val = {59'd0, info};
            end else if (info <= INFO_ARG8) begin
              // 24..27 -> 1, 2, 4 or 8 argument bytes
              arg_left_next = 4'b0001 << info[1:0];
              arg_acc_next  = '0;
              phase_next    = PH_ARG;
            end else begin
              err_step_next = ERR_RESERVED;
            end
          end
          PH_ARG: begin
            arg_acc_next  = acc_new;
            arg_left_next = left_new;
            if (left_new == 4'd0) begin
              hd_go  = 1'b1;
              hd_val = acc_new;
            end
          end
          PH_PAYLOAD: begin
            res_event_next    = EV_PAYLOAD;
            res_data_next     = in_q;
            payload_left_next = pay_new;
            if (pay_new == 64'd0) begin
              phase_next = PH_HEADER;
              fin_req    = 1'b1;
            end
          end
          default: begin
          end
        endcase

        if (hd_go) begin
          res_event_next = EV_HEADER;
          res_arg_next   = hd_val;
          phase_next     = PH_HEADER;
          case (hd_major)
            MT_BSTR, MT_TSTR: begin
              if (hd_val == 64'd0) begin
                fin_req = 1'b1;
              end else begin
                payload_left_next = hd_val;
                phase_next        = PH_PAYLOAD;
              end
            end
            MT_ARRAY, MT_MAP: begin
              if (hd_val[63:COUNT_BITS] != '0) begin
                err_step_next = ERR_WIDE;
              end else if (hd_val == 64'd0) begin
                fin_req = 1'b1;
              end else begin
                push_req = 1'b1;
                // a map holds two items per entry
                push_val = (hd_major == MT_MAP) ? {hd_val[COUNT_BITS-1:0], 1'b0}
                                                : {1'b0, hd_val[COUNT_BITS-1:0]};
              end
            end
            MT_TAG: begin
              push_req = 1'b1;
              push_val = CW'(1);
            end
            default: begin
              fin_req = 1'b1;
            end
          endcase
        end

        if (push_req) begin
          if (sp == SP_W'(NEST_DEPTH)) begin
            err_step_next = ERR_DEEP;
          end else begin
            wr_en   = 1'b1;
            wr_addr = sp[AW-1:0];
            wr_data = push_val;
            sp_next = sp + SP_W'(1);
          end
        end
      end
    end

    if (cmd.fin_read) begin
      if (sp == '0) begin
        done_flag_next = 1'b1;
      end else begin
        rd_en = 1'b1;
      end
    end

    if (cmd.fin_check) begin
      if (rd_data <= CW'(1)) begin
        sp_next = sp_m1;
      end else begin
        wr_en   = 1'b1;
        wr_addr = top_addr;
        wr_data = rd_data - CW'(1);
      end
    end
  end

  // truncation test uses the state left after the item
  always_comb begin
    if (err_step != ERR_NONE) begin
      fin_err = err_step;
    end else if (eob_q && !(phase == PH_HEADER && sp == '0)) begin
      fin_err = ERR_TRUNC;
    end else begin
      fin_err = ERR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      count_stack[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= count_stack[top_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_q  <= in_byte;
      eob_q <= end_of_buffer;
    end
    res_event <= res_event_next;
    res_arg   <= res_arg_next;
    res_data  <= res_data_next;
    err_step  <= err_step_next;
    done_flag <= done_flag_next;
    arg_acc      <= arg_acc_next;
    payload_left <= payload_left_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HEADER;
      arg_left  <= '0;
      cur_major <= '0;
      sticky    <= ERR_NONE;
      sp        <= '0;
      o_valid   <= 1'b0;
    end else begin
      arg_left  <= arg_left_next;
      cur_major <= cur_major_next;
      sp        <= sp_next;
      if (cmd.finalize && sticky == ERR_NONE && fin_err != ERR_NONE) begin
        sticky <= fin_err;
        phase  <= PH_ERROR;
      end else begin
        phase  <= phase_next;
      end
      if (cmd.finalize) begin
        o_valid <= 1'b1;
      end else if (m_tready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finalize) begin
      o_major <= cur_major;
      o_depth <= sp_ext[3:0];
      if (sticky != ERR_NONE || fin_err != ERR_NONE) begin
        o_event <= EV_ERROR;
        o_arg   <= '0;
        o_data  <= '0;
        o_done  <= 1'b0;
        o_err   <= (sticky != ERR_NONE) ? sticky : fin_err;
      end else begin
        o_event <= res_event;
        o_arg   <= res_arg;
        o_data  <= res_data;
        o_done  <= done_flag;
        o_err   <= ERR_NONE;
      end
    end
  end

  assign m_tvalid   = o_valid;
  assign event_res  = o_event;
  assign major_type = o_major;
  assign argument   = o_arg;
  assign data_byte  = o_data;
  assign nest_depth = o_depth;
  assign item_done  = o_done;
  assign error_code = o_err;

  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= SP_W'(NEST_DEPTH))
    else $error("stack pointer past depth");

  a_sticky_hold: assert property (@(posedge clk) disable iff (rst)
    sticky != ERR_NONE |=> sticky == $past(sticky))
    else $error("sticky error changed");

  a_err_event: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_err != ERR_NONE |-> o_event == EV_ERROR && !o_done)
    else $error("error reported without error event");

endmodule

`default_nettype wire

@@ sv/cbor_item_stream_walker_unit.sv @@
// Per byte: capture, decode step, then the registered result load. An item that ends
// adds a stack read; each level visited on a pop cascade adds a read and a check.
// One byte in flight: s_tready is low from capture until the result is loaded, which
// also waits for a free output; the one-read-port stack is walked level by level.
// Reset (rst, synchronous, active high) clears parse state, empties the stack and the
// sticky error; stack contents are not cleared; s_tready rises the cycle after release.
`default_nettype none

module cbor_item_stream_walker_unit
  import cisw_pkg::*;
#(
  parameter int NEST_DEPTH = NEST_DEPTH_DEF,  // open levels, 1..15 (nest_depth is 4 bits)
  parameter int COUNT_BITS = COUNT_BITS_DEF   // widest array/map count, 8..63
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input byte stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
  input  wire logic        s_tlast,   // end_of_buffer
  // decode results
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [87:0]      m_tdata,   // [2:0] major_type, [66:3] argument,
                                      // [74:67] data_byte, [78:75] nest_depth,
                                      // [81:79] error_code, [87:82] zero
  output logic [1:0]       m_tuser,   // [1:0] event_res
  output logic             m_tlast    // item_done
);

  cisw_cmd_t  cmd;
  cisw_stat_t stat;

  logic [2:0]  major_type;
  logic [63:0] argument;
  logic [7:0]  data_byte;
  logic [3:0]  nest_depth;
  logic [2:0]  error_code;

  // Sequencer: capture, decode step, optional pop cascade, then result load.
  cisw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Header decode, argument/payload counters, count stack and output register.
  cisw_dpath #(
    .NEST_DEPTH (NEST_DEPTH),
    .COUNT_BITS (COUNT_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .in_byte       (s_tdata),
    .end_of_buffer (s_tlast),
    .cmd           (cmd),
    .stat          (stat),
    .m_tready      (m_tready),
    .m_tvalid      (m_tvalid),
    .event_res     (m_tuser),
    .major_type    (major_type),
    .argument      (argument),
    .data_byte     (data_byte),
    .nest_depth    (nest_depth),
    .item_done     (m_tlast),
    .error_code    (error_code)
  );

  // Pack result fields, lowest field first, padded to whole bytes.
  assign m_tdata = {6'd0, error_code, nest_depth, data_byte, argument, major_type};

endmodule

`default_nettype wire
